[sv/pfo_pkg.sv]
package pfo_pkg;

  localparam int MAX_NODES   = 64;
  localparam int NODE_W      = 6;
  localparam int ADDR_W      = $clog2(MAX_NODES);
  localparam int CNT_W       = $clog2(MAX_NODES + 1);
  localparam int CMP_W       = NODE_W + 1;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_W       = 6;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROOT_ENABLE = 1'b0,
    REG_ROOT_NODE   = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic              has_parent;
    logic [NODE_W-1:0] parent;
  } parent_entry_t;

  localparam int PENT_W = $bits(parent_entry_t);

  typedef struct packed {
    logic              start;
    logic [CNT_W-1:0]  count;
    logic              root_enable;
    logic [NODE_W-1:0] root_node;
    logic              overflow;
  } sort_cmd_t;

  typedef struct packed {
    logic busy;
  } sort_status_t;

endpackage

[sv/pfo_ram.sv]
module pfo_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/pfo_sort.sv]
module pfo_sort
  import pfo_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  sort_cmd_t              cmd,
  output sort_status_t           status,
  output logic [ADDR_W-1:0]      par_raddr,
  input  parent_entry_t          par_rdata,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,  // node_index, order_position
  output logic                   m_tlast,
  output logic                   m_tuser   // overflow
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_SCAN = 5'b00010,
    ST_WALK = 5'b00100,
    ST_COPY = 5'b01000,
    ST_EMIT = 5'b10000
  } state_t;

  localparam logic [ADDR_W-1:0] TOP = ADDR_W'(MAX_NODES - 1);

  state_t state, state_next;

  logic [MAX_NODES-1:0] placed;
  logic [CNT_W-1:0]     idx;
  logic [CNT_W-1:0]     len;
  logic [CNT_W-1:0]     wp;
  logic [CNT_W-1:0]     src;
  logic [CNT_W-1:0]     pos_q;
  logic                 pv;
  logic [CNT_W-1:0]     count_q;
  logic [NODE_W-1:0]    root_q;
  logic                 swap_q;
  logic                 ovf_q;
  logic [ADDR_W-1:0]    root_pos;
  logic [NODE_W-1:0]    first_q;

  logic [NODE_W-1:0] out_node;
  logic [NODE_W-1:0] out_pos;

  logic              ord_we;
  logic [ADDR_W-1:0] ord_waddr;
  logic [NODE_W-1:0] ord_wdata;
  logic [ADDR_W-1:0] ord_raddr;
  logic [NODE_W-1:0] ord_rdata;

  logic rd_issue;
  logic p_ok;
  logic out_free;
  logic src_more;
  logic emit_more;
  logic [NODE_W-1:0] emit_node;

  pfo_ram #(
    .DEPTH(MAX_NODES),
    .WIDTH(NODE_W)
  ) u_order_ram (
    .clk  (clk),
    .we   (ord_we),
    .waddr(ord_waddr),
    .wdata(ord_wdata),
    .raddr(ord_raddr),
    .rdata(ord_rdata)
  );

  // a parent counts only if flagged, inside the set and not yet placed
  assign p_ok = par_rdata.has_parent
             && ({1'b0, par_rdata.parent} < CMP_W'(count_q))
             && !placed[par_rdata.parent[ADDR_W-1:0]];

  assign out_free  = !m_tvalid || m_tready;
  assign src_more  = src < CNT_W'(MAX_NODES);
  assign emit_more = src < count_q;

  always_comb begin
    state_next = state;
    ord_we     = 1'b0;
    ord_waddr  = '0;
    ord_wdata  = '0;
    ord_raddr  = src[ADDR_W-1:0];
    par_raddr  = idx[ADDR_W-1:0];
    rd_issue   = 1'b0;
    case (state)
      ST_IDLE: begin
        if (cmd.start) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (idx == count_q) begin
          state_next = ST_EMIT;
        end else if (!placed[idx[ADDR_W-1:0]]) begin
          // chain is staged from the top of the list downward
          ord_we     = 1'b1;
          ord_waddr  = TOP;
          ord_wdata  = NODE_W'(idx);
          state_next = ST_WALK;
        end
      end
      ST_WALK: begin
        par_raddr = par_rdata.parent[ADDR_W-1:0];
        if (p_ok) begin
          ord_we    = 1'b1;
          ord_waddr = wp[ADDR_W-1:0];
          ord_wdata = par_rdata.parent;
        end else begin
          state_next = ST_COPY;
        end
      end
      ST_COPY: begin
        // move the staged chain down to the end of the order, eldest first
        rd_issue = src_more;
        if (pv) begin
          ord_we    = 1'b1;
          ord_waddr = len[ADDR_W-1:0];
          ord_wdata = ord_rdata;
        end
        if (!src_more && !pv) state_next = ST_SCAN;
      end
      ST_EMIT: begin
        rd_issue = !pv && out_free && emit_more;
        if (!emit_more && !pv) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // root swap is applied on the way out
  always_comb begin
    if (swap_q && pos_q == '0) begin
      emit_node = root_q;
    end else if (swap_q && pos_q[ADDR_W-1:0] == root_pos) begin
      emit_node = first_q;
    end else begin
      emit_node = ord_rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      pv       <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      pv    <= rd_issue;
      if (state == ST_EMIT && pv) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (cmd.start) begin
          count_q <= cmd.count;
          root_q  <= cmd.root_node;
          ovf_q   <= cmd.overflow;
          swap_q  <= cmd.root_enable && ({1'b0, cmd.root_node} < CMP_W'(cmd.count));
          placed  <= '0;
          idx     <= '0;
          len     <= '0;
        end
      end
      ST_SCAN: begin
        if (idx == count_q) begin
          src <= '0;
        end else begin
          idx <= idx + 1'b1;
          if (!placed[idx[ADDR_W-1:0]]) begin
            placed[idx[ADDR_W-1:0]] <= 1'b1;
            wp <= CNT_W'(MAX_NODES - 2);
          end
        end
      end
      ST_WALK: begin
        if (p_ok) begin
          placed[par_rdata.parent[ADDR_W-1:0]] <= 1'b1;
          wp <= wp - 1'b1;
        end else begin
          src <= wp + 1'b1;
        end
      end
      ST_COPY: begin
        if (rd_issue) src <= src + 1'b1;
        if (pv) begin
          len <= len + 1'b1;
          if (swap_q && ord_rdata == root_q) root_pos <= len[ADDR_W-1:0];
          if (len == '0) first_q <= ord_rdata;
        end
      end
      ST_EMIT: begin
        if (rd_issue) begin
          src   <= src + 1'b1;
          pos_q <= src;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == ST_EMIT && pv) begin
      out_node <= emit_node;
      out_pos  <= NODE_W'(pos_q);
      m_tlast  <= (CNT_W'(pos_q + 1'b1) == count_q);
      m_tuser  <= ovf_q;
    end
  end

  assign m_tdata = {{(OUT_TDATA_W - 2 * NODE_W){1'b0}}, out_pos, out_node};

  assign status.busy = (state != ST_IDLE);

endmodule

[sv/parent_first_tree_order.sv]
// Parent-first tree order. Nodes stream in one word per cycle; the node number is the
// arrival order in the set and tuser flags that the low tdata bits name a parent
// (a parent at or past the final node count is taken as none). Up to 64 nodes are kept,
// later ones are dropped and the overflow flag rides on every result of that set. The
// word with tlast closes the set: input then stalls while the order is built from the
// parent memory, one parent read per cycle along each ancestor chain, the chain being
// staged in the order memory and copied into place. Results leave through the output
// register from the single read port of the order memory, a new read issuing only once
// the previous word is loaded and the output is free, with the node number and position
// in tdata and tlast on the final one. When enabled, the configured root node is swapped
// into position zero if it exists in the set. No clearing pass follows reset.
module parent_first_tree_order
  import pfo_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,   // parent_node
  input  logic                   s_tuser,   // has_parent
  input  logic                   s_tlast,   // last_node
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,   // node_index, order_position
  output logic                   m_tuser,   // overflow
  output logic                   m_tlast,   // last_result
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]       cfg_data
);

  logic              root_enable;
  logic [NODE_W-1:0] root_node;
  logic [CNT_W-1:0]  node_count;
  logic              overflow_seen;

  logic              accept;
  logic              has_room;
  parent_entry_t     par_wdata;
  parent_entry_t     par_rdata;
  logic [ADDR_W-1:0] par_raddr;
  sort_cmd_t         cmd;
  sort_status_t      status;

  assign s_tready = !status.busy;
  assign accept   = s_tvalid && s_tready;
  assign has_room = node_count < CNT_W'(MAX_NODES);

  assign par_wdata.has_parent = s_tuser;
  assign par_wdata.parent     = s_tdata[NODE_W-1:0];

  pfo_ram #(
    .DEPTH(MAX_NODES),
    .WIDTH(PENT_W)
  ) u_parent_ram (
    .clk  (clk),
    .we   (accept && has_room),
    .waddr(node_count[ADDR_W-1:0]),
    .wdata(par_wdata),
    .raddr(par_raddr),
    .rdata(par_rdata)
  );

  assign cmd.start       = accept && s_tlast;
  assign cmd.count       = has_room ? node_count + 1'b1 : node_count;
  assign cmd.root_enable = root_enable;
  assign cmd.root_node   = root_node;
  assign cmd.overflow    = overflow_seen || !has_room;

  always_ff @(posedge clk) begin
    if (rst) begin
      root_enable <= 1'b0;
      root_node   <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_ROOT_ENABLE: root_enable <= cfg_data[0];
        REG_ROOT_NODE:   root_node   <= cfg_data[NODE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count    <= '0;
      overflow_seen <= 1'b0;
    end else if (accept) begin
      if (s_tlast) begin
        node_count    <= '0;
        overflow_seen <= 1'b0;
      end else if (has_room) begin
        node_count <= node_count + 1'b1;
      end else begin
        overflow_seen <= 1'b1;
      end
    end
  end

  pfo_sort u_sort (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .status   (status),
    .par_raddr(par_raddr),
    .par_rdata(par_rdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

endmodule
